### rtl/descriptor_slot_table_top_macros.svh
// assertion macros used by the checker of the slot table
// all of them sample on i_clk; the first two are muted while i_rst_n is low
`ifndef DESCRIPTOR_SLOT_TABLE_TOP_MACROS_SVH
`define DESCRIPTOR_SLOT_TABLE_TOP_MACROS_SVH

// same-cycle implication
`define DST_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("slot table check failed");

// next-cycle implication
`define DST_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("slot table check failed");

// next-cycle implication that also holds across reset
`define DST_ASSERT_NEXT_NORST(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("slot table check failed");

`endif

### rtl/dst_pkg.sv
package dst_pkg;

    // table geometry
    localparam int unsigned TABLE_DEPTH = 64;
    localparam int unsigned HANDLE_BITS = 32;
    localparam int unsigned ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);

    // fixed field widths
    localparam int unsigned REQ_W = 3;
    localparam int unsigned HND_W = 32;
    localparam int unsigned IDX_W = 6;
    localparam int unsigned FLG_W = 8;
    localparam int unsigned ST_W  = 2;
    localparam int unsigned EXT_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;

    // config port
    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 32;
    localparam logic REG_ALLOWED = 1'b0;
    localparam logic REG_COE     = 1'b1;
    localparam logic [FLG_W-1:0] ALLOWED_RESET = 8'd3;
    localparam logic [FLG_W-1:0] COE_RESET     = 8'd1;

    // request codes
    localparam logic [REQ_W-1:0] REQ_ALLOC = 3'd0;
    localparam logic [REQ_W-1:0] REQ_DUP   = 3'd1;
    localparam logic [REQ_W-1:0] REQ_COPY  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_FREE  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_GET   = 3'd4;
    localparam logic [REQ_W-1:0] REQ_SETF  = 3'd5;
    localparam logic [REQ_W-1:0] REQ_GETF  = 3'd6;
    localparam logic [REQ_W-1:0] REQ_EXEC  = 3'd7;

    // status codes
    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_INVALID = 2'd1;
    localparam logic [ST_W-1:0] ST_BADF    = 2'd2;
    localparam logic [ST_W-1:0] ST_FULL    = 2'd3;

    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic [HND_W-1:0] handle;
        logic [IDX_W-1:0] source_index;
        logic [IDX_W-1:0] target_index;
        logic [FLG_W-1:0] flags;
    } t_req;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [IDX_W-1:0] slot_index;
        logic [HND_W-1:0] handle_out;
        logic [FLG_W-1:0] flags_out;
    } t_rsp;

    typedef struct packed {
        logic [FLG_W-1:0]       flags;
        logic [HANDLE_BITS-1:0] handle;
    } t_row;

endpackage

### rtl/descriptor_slot_table_top.sv
// channel   direction  handshake                   payload
// request   in         i_in_valid / o_in_ready     i_in_data  (dst_pkg::t_req)
// result    out        o_out_valid / i_out_ready   o_out_data (dst_pkg::t_rsp)
// config    in         psel/penable/pwrite/pready  paddr, pwdata, prdata
//
// one request at a time; get, free, set flags, get flags and copy go through read,
// check and done, as does a duplicate refused on its flags; a request refused at
// accept goes straight to done; allocate and duplicate scan for the lowest free slot;
// exec sweeps every slot; the single table read port sets the pace of these steps
// a finished result waits in the output register; only the last step of the next
// request stalls on it; synchronous reset clears control and valid bits, presets config
module descriptor_slot_table_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  dst_pkg::t_req                       i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output dst_pkg::t_rsp                       o_out_data,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [dst_pkg::CFG_ADDR_W-1:0]      paddr,
    input  logic [dst_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic [dst_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                pready
);

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,   // waiting for a request transaction
        S_RD,     // one table read of a named slot
        S_CHK,    // decide on the named slot
        S_SCAN,   // lowest free slot search, one slot a cycle
        S_SWEEP,  // exec sweep, one slot a cycle
        S_DONE    // hand the result to the output register
    } t_state;

    // table storage, valid bits stand in for the all-zero reset
    dst_pkg::t_row                      r_mem [dst_pkg::TABLE_DEPTH];
    logic [dst_pkg::TABLE_DEPTH-1:0]    r_valid;
    dst_pkg::t_row                      r_rd_data;
    logic                               r_rd_hit;
    logic                               r_rd_pend;
    logic [dst_pkg::ADDR_W-1:0]         r_rd_addr;

    // sequencer
    t_state                             r_state;
    dst_pkg::t_req                      r_req;
    logic [dst_pkg::HANDLE_BITS-1:0]    r_hold;
    logic [dst_pkg::CNT_W-1:0]          r_scan;
    logic [dst_pkg::ADDR_W-1:0]         r_addr;
    dst_pkg::t_rsp                      r_res;
    logic                               r_out_valid;
    dst_pkg::t_rsp                      r_out_data;
    logic [dst_pkg::FLG_W-1:0]          r_allowed;
    logic [dst_pkg::FLG_W-1:0]          r_coe;

    logic                               acc;
    logic                               cfg_wr;
    logic                               in_flags_bad;
    logic                               in_src_ok;
    logic                               in_dst_ok;
    logic                               req_dst_ok;
    logic                               req_flags_bad;
    logic                               scan_more;
    logic                               done_fire;
    logic [dst_pkg::ST_W-1:0]           acc_status;
    t_state                             acc_state;
    logic [dst_pkg::ADDR_W-1:0]         acc_addr;
    logic [dst_pkg::CNT_W-1:0]          acc_scan;
    dst_pkg::t_row                      row;
    logic                               row_busy;
    logic                               found;
    logic                               rd_en;
    logic [dst_pkg::ADDR_W-1:0]         rd_addr;
    logic                               wr_en;
    logic [dst_pkg::ADDR_W-1:0]         wr_addr;
    dst_pkg::t_row                      wr_row;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign pready      = 1'b1;

    assign acc    = i_in_valid && o_in_ready;
    assign cfg_wr = psel && penable && pwrite && pready;

    // request checks on the incoming transaction
    assign in_flags_bad = |(i_in_data.flags & ~r_allowed);
    assign in_src_ok    = dst_pkg::EXT_W'(i_in_data.source_index)
                          < dst_pkg::EXT_W'(dst_pkg::TABLE_DEPTH);
    assign in_dst_ok    = dst_pkg::EXT_W'(i_in_data.target_index)
                          < dst_pkg::EXT_W'(dst_pkg::TABLE_DEPTH);
    assign req_dst_ok   = dst_pkg::EXT_W'(r_req.target_index)
                          < dst_pkg::EXT_W'(dst_pkg::TABLE_DEPTH);
    assign req_flags_bad = |(r_req.flags & ~r_allowed);
    assign scan_more    = r_scan < dst_pkg::CNT_W'(dst_pkg::TABLE_DEPTH);

    // result leaves for the output register
    assign done_fire = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    // row read last cycle; an unwritten slot reads as zero
    assign row      = r_rd_hit ? r_rd_data : '0;
    assign row_busy = (row.handle != '0);
    assign found    = r_rd_pend && !row_busy;

    // config readback
    always_comb begin
        unique case (paddr[2])
            dst_pkg::REG_ALLOWED: prdata = dst_pkg::CFG_DATA_W'(r_allowed);
            dst_pkg::REG_COE:     prdata = dst_pkg::CFG_DATA_W'(r_coe);
        endcase
    end

    // decode of an incoming request: early status, first state, slot to read
    always_comb begin
        acc_status = dst_pkg::ST_OK;
        acc_state  = S_RD;
        acc_addr   = dst_pkg::ADDR_W'(i_in_data.target_index);
        // a minimum index past the table makes the search come up empty
        acc_scan   = in_dst_ok ? dst_pkg::CNT_W'(i_in_data.target_index)
                               : dst_pkg::CNT_W'(dst_pkg::TABLE_DEPTH);
        unique case (i_in_data.req_type)
            dst_pkg::REQ_ALLOC: begin
                if (in_flags_bad) begin
                    acc_status = dst_pkg::ST_INVALID;
                    acc_state  = S_DONE;
                end else begin
                    acc_state = S_SCAN;
                end
            end
            dst_pkg::REQ_DUP: begin
                // source checked before flags
                acc_addr = dst_pkg::ADDR_W'(i_in_data.source_index);
                if (!in_src_ok) begin
                    acc_status = dst_pkg::ST_BADF;
                    acc_state  = S_DONE;
                end
            end
            dst_pkg::REQ_COPY: begin
                acc_addr = dst_pkg::ADDR_W'(i_in_data.source_index);
                if (in_flags_bad) begin
                    acc_status = dst_pkg::ST_INVALID;
                    acc_state  = S_DONE;
                end else if (!in_src_ok) begin
                    acc_status = dst_pkg::ST_BADF;
                    acc_state  = S_DONE;
                end
            end
            dst_pkg::REQ_SETF: begin
                if (in_flags_bad) begin
                    acc_status = dst_pkg::ST_INVALID;
                    acc_state  = S_DONE;
                end else if (!in_dst_ok) begin
                    acc_status = dst_pkg::ST_BADF;
                    acc_state  = S_DONE;
                end
            end
            dst_pkg::REQ_FREE, dst_pkg::REQ_GET, dst_pkg::REQ_GETF: begin
                if (!in_dst_ok) begin
                    acc_status = dst_pkg::ST_BADF;
                    acc_state  = S_DONE;
                end
            end
            dst_pkg::REQ_EXEC: begin
                acc_scan  = '0;
                acc_state = S_SWEEP;
            end
        endcase
    end

    // table port control per state
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_addr;
        wr_en   = 1'b0;
        wr_addr = r_addr;
        wr_row  = row;
        unique case (r_state)
            S_RD: begin
                rd_en = 1'b1;
            end
            S_CHK: begin
                if (row_busy) begin
                    unique case (r_req.req_type)
                        dst_pkg::REQ_COPY: begin
                            // destination takes the source handle and new flags
                            wr_en   = (r_req.source_index != r_req.target_index)
                                      && req_dst_ok;
                            wr_addr = dst_pkg::ADDR_W'(r_req.target_index);
                            wr_row  = '{flags: r_req.flags, handle: row.handle};
                        end
                        dst_pkg::REQ_FREE: begin
                            // free keeps the flags byte
                            wr_en  = 1'b1;
                            wr_row = '{flags: row.flags, handle: '0};
                        end
                        dst_pkg::REQ_SETF: begin
                            wr_en  = 1'b1;
                            wr_row = '{flags: r_req.flags, handle: row.handle};
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (found) begin
                    wr_en   = 1'b1;
                    wr_addr = r_rd_addr;
                    wr_row  = '{flags: r_req.flags, handle: r_hold};
                end else if (scan_more) begin
                    rd_en   = 1'b1;
                    rd_addr = r_scan[dst_pkg::ADDR_W-1:0];
                end
            end
            S_SWEEP: begin
                // write-back of slot n overlaps the read of slot n+1
                wr_en   = r_rd_pend && row_busy && (|(row.flags & r_coe));
                wr_addr = r_rd_addr;
                wr_row  = '{flags: row.flags, handle: '0};
                rd_en   = scan_more;
                rd_addr = r_scan[dst_pkg::ADDR_W-1:0];
            end
            default: begin
            end
        endcase
    end

    // table memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_row;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_rd_pend <= 1'b0;
            r_rd_hit  <= 1'b0;
        end else begin
            if (wr_en) begin
                r_valid[wr_addr] <= 1'b1;
            end
            r_rd_pend <= rd_en;
            if (rd_en) begin
                r_rd_hit  <= r_valid[rd_addr];
                r_rd_addr <= rd_addr;
            end
        end
    end

    // sequencer, config registers and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_allowed   <= dst_pkg::ALLOWED_RESET;
            r_coe       <= dst_pkg::COE_RESET;
        end else begin
            if (cfg_wr) begin
                unique case (paddr[2])
                    dst_pkg::REG_ALLOWED: r_allowed <= pwdata[dst_pkg::FLG_W-1:0];
                    dst_pkg::REG_COE:     r_coe     <= pwdata[dst_pkg::FLG_W-1:0];
                endcase
            end
            // a new result replaces one leaving in the same cycle
            if (done_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (acc) begin
                        r_req   <= i_in_data;
                        r_res   <= '{status: acc_status, slot_index: '0,
                                     handle_out: '0, flags_out: '0};
                        r_hold  <= dst_pkg::HANDLE_BITS'(i_in_data.handle);
                        r_scan  <= acc_scan;
                        r_addr  <= acc_addr;
                        r_state <= acc_state;
                    end
                end
                S_RD: begin
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    if (!row_busy) begin
                        r_res.status <= dst_pkg::ST_BADF;
                        r_state      <= S_DONE;
                    end else if (r_req.req_type == dst_pkg::REQ_DUP) begin
                        // live source, flags come next
                        if (req_flags_bad) begin
                            r_res.status <= dst_pkg::ST_INVALID;
                            r_state      <= S_DONE;
                        end else begin
                            r_hold  <= row.handle;
                            r_state <= S_SCAN;
                        end
                    end else begin
                        r_state <= S_DONE;
                        unique case (r_req.req_type)
                            dst_pkg::REQ_COPY: begin
                                if (r_req.source_index == r_req.target_index) begin
                                    r_res.status <= dst_pkg::ST_INVALID;
                                end else if (!req_dst_ok) begin
                                    r_res.status <= dst_pkg::ST_FULL;
                                end else begin
                                    r_res.slot_index <= r_req.target_index;
                                end
                            end
                            dst_pkg::REQ_FREE, dst_pkg::REQ_GET: begin
                                r_res.slot_index <= r_req.target_index;
                                r_res.handle_out <= dst_pkg::HND_W'(row.handle);
                            end
                            dst_pkg::REQ_SETF: begin
                                r_res.slot_index <= r_req.target_index;
                            end
                            dst_pkg::REQ_GETF: begin
                                r_res.slot_index <= r_req.target_index;
                                r_res.flags_out  <= row.flags;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (found) begin
                        r_res.slot_index <= dst_pkg::IDX_W'(r_rd_addr);
                        r_state          <= S_DONE;
                    end else if (scan_more) begin
                        r_scan <= r_scan + dst_pkg::CNT_W'(1);
                    end else if (!r_rd_pend) begin
                        r_res.status <= dst_pkg::ST_FULL;
                        r_state      <= S_DONE;
                    end
                end
                S_SWEEP: begin
                    if (scan_more) begin
                        r_scan <= r_scan + dst_pkg::CNT_W'(1);
                    end else if (!r_rd_pend) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (done_fire) begin
                        r_out_data <= r_res;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

### rtl/dst_check.sv
`include "descriptor_slot_table_top_macros.svh"

module dst_check (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_valid,
    input logic                             o_in_ready,
    input logic                             o_out_valid,
    input logic                             i_out_ready,
    input dst_pkg::t_rsp                    o_out_data
);

    // the request port is never ready in the cycle after an accept
    `DST_ASSERT_NEXT(a_busy_after_accept, i_in_valid && o_in_ready, !o_in_ready)

    // a failed request reports no slot, handle or flags
    `DST_ASSERT_IMPL(a_fail_zero, o_out_valid && (o_out_data.status != dst_pkg::ST_OK), (o_out_data.slot_index == '0) && (o_out_data.handle_out == '0) && (o_out_data.flags_out == '0))

    // a stalled result holds
    `DST_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data))

    // reset empties the output register
    `DST_ASSERT_NEXT_NORST(a_reset_out, !i_rst_n, !o_out_valid)

endmodule

bind descriptor_slot_table_top dst_check u_dst_check (.*);
